/* rtl/jsu_pkg.sv */
`default_nettype none

package jsu_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int MAX_RESULTS = 4;
    localparam int SUB_W       = $clog2(MAX_RESULTS);

    localparam logic [7:0] CTRL_LIMIT = 8'h20;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_B       = 8'h62;
    localparam logic [7:0] CH_F       = 8'h66;
    localparam logic [7:0] CH_N       = 8'h6E;
    localparam logic [7:0] CH_R       = 8'h72;
    localparam logic [7:0] CH_T       = 8'h74;
    localparam logic [7:0] CH_U       = 8'h75;

    localparam logic [7:0] CC_BS      = 8'h08;
    localparam logic [7:0] CC_FF      = 8'h0C;
    localparam logic [7:0] CC_LF      = 8'h0A;
    localparam logic [7:0] CC_CR      = 8'h0D;
    localparam logic [7:0] CC_TAB     = 8'h09;

    localparam logic [5:0] HIGH_SUR_TAG = 6'b110110;
    localparam logic [5:0] LOW_SUR_TAG  = 6'b110111;

    localparam logic [20:0] SUPP_BASE = 21'h10000;
    localparam logic [20:0] MAX_1B    = 21'h7F;
    localparam logic [20:0] MAX_2B    = 21'h7FF;
    localparam logic [20:0] MAX_3B    = 21'hFFFF;

    localparam logic [7:0] LEAD_2B = 8'hC0;
    localparam logic [7:0] LEAD_3B = 8'hE0;
    localparam logic [7:0] LEAD_4B = 8'hF0;
    localparam logic [7:0] CONT_B  = 8'h80;

    typedef enum logic [3:0] {
        ERR_NONE     = 4'd0,
        ERR_NO_QUOTE = 4'd1,
        ERR_CTRL     = 4'd2,
        ERR_BAD_ESC  = 4'd3,
        ERR_BAD_HEX  = 4'd4,
        ERR_BAD_PAIR = 4'd5,
        ERR_LONE_LOW = 4'd6,
        ERR_EXP_BS   = 4'd7,
        ERR_EXP_U    = 4'd8,
        ERR_UNTERM   = 4'd9
    } t_err;

    typedef enum logic [6:0] {
        M_IDLE   = 7'b0000001,
        M_BODY   = 7'b0000010,
        M_ESC    = 7'b0000100,
        M_HEX1   = 7'b0001000,
        M_EXP_BS = 7'b0010000,
        M_EXP_U  = 7'b0100000,
        M_HEX2   = 7'b1000000
    } t_mode;

    // one decoded item: up to four content bytes, or a single done/error result
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [SUB_W-1:0]            nm1;
        logic                        is_byte;
        logic                        done;
        t_err                        err;
    } t_group;

    // {valid, digit}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic t_group utf8_group(input logic [20:0] cp);
        t_group g;
        g         = '0;
        g.is_byte = 1'b1;
        g.err     = ERR_NONE;
        if (cp <= MAX_1B) begin
            g.bytes[0] = cp[7:0];
            g.nm1      = SUB_W'(0);
        end else if (cp <= MAX_2B) begin
            g.bytes[0] = LEAD_2B | {3'b000, cp[10:6]};
            g.bytes[1] = CONT_B | {2'b00, cp[5:0]};
            g.nm1      = SUB_W'(1);
        end else if (cp <= MAX_3B) begin
            g.bytes[0] = LEAD_3B | {4'b0000, cp[15:12]};
            g.bytes[1] = CONT_B | {2'b00, cp[11:6]};
            g.bytes[2] = CONT_B | {2'b00, cp[5:0]};
            g.nm1      = SUB_W'(2);
        end else begin
            g.bytes[0] = LEAD_4B | {5'b00000, cp[20:18]};
            g.bytes[1] = CONT_B | {2'b00, cp[17:12]};
            g.bytes[2] = CONT_B | {2'b00, cp[11:6]};
            g.bytes[3] = CONT_B | {2'b00, cp[5:0]};
            g.nm1      = SUB_W'(3);
        end
        return g;
    endfunction

endpackage

`default_nettype wire

/* rtl/jsu_if.sv */
`default_nettype none

interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_input;

    modport source (output valid, output data_byte, output end_of_input, input ready);
    modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
    logic       string_done;
    logic [3:0] error_code;

    modport source (output valid, output out_byte, output byte_valid, output last,
                    output string_done, output error_code, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input last,
                    input string_done, input error_code, output ready);
endinterface

`default_nettype wire

/* rtl/jsu_decode.sv */
`default_nettype none

module jsu_decode (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    jsu_in_if.sink         i_in,
    input  wire logic      i_full,
    output logic           o_push,
    output jsu_pkg::t_group o_group
);
    import jsu_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_eoi;

    t_mode       r_mode, n_mode;
    logic [1:0]  r_hex_cnt, n_hex_cnt;
    logic [11:0] r_code, n_code;
    logic [9:0]  r_high, n_high;

    logic        adv;
    logic        accept;
    logic        fail;
    t_err        fail_err;
    logic [4:0]  hv;
    logic [15:0] cu_new;
    logic        esc_hit;
    logic [7:0]  esc_byte;

    assign adv        = r_in_valid && !i_full;
    assign i_in.ready = !r_in_valid || adv;
    assign accept     = i_in.valid && i_in.ready;

    assign hv     = hex_value(r_in_byte);
    assign cu_new = {r_code, hv[3:0]};

    always_comb begin
        esc_hit  = 1'b1;
        esc_byte = r_in_byte;
        case (r_in_byte) inside
            CH_QUOTE, CH_BSLASH, CH_SLASH: esc_byte = r_in_byte;
            CH_B:    esc_byte = CC_BS;
            CH_F:    esc_byte = CC_FF;
            CH_N:    esc_byte = CC_LF;
            CH_R:    esc_byte = CC_CR;
            CH_T:    esc_byte = CC_TAB;
            default: esc_hit  = 1'b0;
        endcase
    end

    always_comb begin
        n_mode    = r_mode;
        n_hex_cnt = r_hex_cnt;
        n_code    = r_code;
        n_high    = r_high;
        o_push    = 1'b0;
        o_group   = '0;
        fail      = 1'b0;
        fail_err  = ERR_NONE;

        if (adv) begin
            if (r_in_eoi) begin
                fail = 1'b1;
                unique case (r_mode) inside
                    M_EXP_BS:                      fail_err = ERR_EXP_BS;
                    M_EXP_U:                       fail_err = ERR_EXP_U;
                    M_BODY, M_ESC, M_HEX1, M_HEX2: fail_err = ERR_UNTERM;
                    default:                       fail_err = ERR_NO_QUOTE;
                endcase
            end else begin
                unique case (r_mode) inside
                    M_BODY: begin
                        if (r_in_byte == CH_QUOTE) begin
                            n_mode       = M_IDLE;
                            o_push       = 1'b1;
                            o_group.done = 1'b1;
                        end else if (r_in_byte < CTRL_LIMIT) begin
                            fail     = 1'b1;
                            fail_err = ERR_CTRL;
                        end else if (r_in_byte == CH_BSLASH) begin
                            n_mode = M_ESC;
                        end else begin
                            o_push           = 1'b1;
                            o_group.is_byte  = 1'b1;
                            o_group.bytes[0] = r_in_byte;
                        end
                    end
                    M_ESC: begin
                        if (r_in_byte == CH_U) begin
                            n_mode    = M_HEX1;
                            n_hex_cnt = '0;
                            n_code    = '0;
                        end else if (esc_hit) begin
                            n_mode           = M_BODY;
                            o_push           = 1'b1;
                            o_group.is_byte  = 1'b1;
                            o_group.bytes[0] = esc_byte;
                        end else begin
                            fail     = 1'b1;
                            fail_err = ERR_BAD_ESC;
                        end
                    end
                    M_EXP_BS: begin
                        if (r_in_byte == CH_BSLASH) begin
                            n_mode = M_EXP_U;
                        end else begin
                            fail     = 1'b1;
                            fail_err = ERR_EXP_BS;
                        end
                    end
                    M_EXP_U: begin
                        if (r_in_byte == CH_U) begin
                            n_mode    = M_HEX2;
                            n_hex_cnt = '0;
                            n_code    = '0;
                        end else begin
                            fail     = 1'b1;
                            fail_err = ERR_EXP_U;
                        end
                    end
                    M_HEX1, M_HEX2: begin
                        if (!hv[4]) begin
                            fail     = 1'b1;
                            fail_err = ERR_BAD_HEX;
                        end else if (r_hex_cnt != 2'd3) begin
                            n_hex_cnt = r_hex_cnt + 2'd1;
                            n_code    = cu_new[11:0];
                        end else begin
                            n_hex_cnt = '0;
                            n_code    = '0;
                            if (r_mode == M_HEX1) begin
                                if (cu_new[15:10] == HIGH_SUR_TAG) begin
                                    n_high = cu_new[9:0];
                                    n_mode = M_EXP_BS;
                                end else if (cu_new[15:10] == LOW_SUR_TAG) begin
                                    fail     = 1'b1;
                                    fail_err = ERR_LONE_LOW;
                                end else begin
                                    n_mode  = M_BODY;
                                    o_push  = 1'b1;
                                    o_group = utf8_group({5'd0, cu_new});
                                end
                            end else begin
                                if (cu_new[15:10] != LOW_SUR_TAG) begin
                                    fail     = 1'b1;
                                    fail_err = ERR_BAD_PAIR;
                                end else begin
                                    n_mode  = M_BODY;
                                    o_push  = 1'b1;
                                    o_group = utf8_group(SUPP_BASE +
                                                         {1'b0, r_high, cu_new[9:0]});
                                end
                            end
                        end
                    end
                    default: begin
                        if (r_in_byte == CH_QUOTE) begin
                            n_mode = M_BODY;
                        end else begin
                            fail     = 1'b1;
                            fail_err = ERR_NO_QUOTE;
                        end
                    end
                endcase
            end

            if (fail) begin
                n_mode      = M_IDLE;
                n_hex_cnt   = '0;
                n_code      = '0;
                n_high      = '0;
                o_push      = 1'b1;
                o_group     = '0;
                o_group.err = fail_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= M_IDLE;
            r_hex_cnt  <= '0;
            r_code     <= '0;
            r_high     <= '0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            r_mode    <= n_mode;
            r_hex_cnt <= n_hex_cnt;
            r_code    <= n_code;
            r_high    <= n_high;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_in.data_byte;
            r_in_eoi  <= i_in.end_of_input;
        end
    end

endmodule

`default_nettype wire

/* rtl/jsu_queue.sv */
`default_nettype none

module jsu_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire jsu_pkg::t_group  i_group,
    output logic                  o_full,
    jsu_out_if.source             o_out
);
    import jsu_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_group           r_q [QUEUE_DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [PW:0]      r_cnt;
    logic [SUB_W-1:0] r_sub;

    t_group head;
    logic   last_res;
    logic   xfer;
    logic   pop;

    assign head     = r_q[r_rp];
    assign last_res = !head.is_byte || (r_sub == head.nm1);
    assign xfer     = o_out.valid && o_out.ready;
    assign pop      = xfer && last_res;
    assign o_full   = (r_cnt == (PW+1)'(QUEUE_DEPTH));

    assign o_out.valid       = (r_cnt != '0);
    assign o_out.out_byte    = head.is_byte ? head.bytes[r_sub] : 8'h00;
    assign o_out.byte_valid  = head.is_byte;
    assign o_out.last        = last_res;
    assign o_out.string_done = head.done;
    assign o_out.error_code  = head.err;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_group;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
            r_sub <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (pop) begin
                r_rp <= r_rp + PW'(1);
            end
            case ({i_push, pop})
                2'b10:   r_cnt <= r_cnt + (PW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (PW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
            if (xfer) begin
                r_sub <= last_res ? '0 : r_sub + SUB_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/json_string_unescape_utf8.sv */
// The input byte is registered in the decoder, decoded and written into the queue; results
// are presented from the queue head. Throughput: one input item per cycle while the queue
// has room; one result per cycle on the output while the output is ready, so an item
// that decodes to n UTF-8 bytes gives n results. A 4-entry queue of decoded items sits
// between the decoder and the output; the decoder stalls while the queue is full.
// Reset: i_rst_n synchronous, active low; returns to idle and empties the queue.
`default_nettype none

module json_string_unescape_utf8 (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    jsu_in_if.sink    i_in,
    jsu_out_if.source o_out
);
    import jsu_pkg::*;

    logic   push;
    logic   full;
    t_group group;

    jsu_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_group (group)
    );

    jsu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_group (group),
        .o_full  (full),
        .o_out   (o_out)
    );

`ifndef NO_ASSERTIONS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && full))
        else $error("decoded item written into a full queue");

    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.error_code != ERR_NONE) |-> (o_out.last && !o_out.byte_valid
                                                           && !o_out.string_done))
        else $error("error result not a single terminal result");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.string_done) |-> (o_out.last && !o_out.byte_valid))
        else $error("done result not a single terminal result");
`endif

endmodule

`default_nettype wire

/* tb/tb_json_string_unescape_utf8.sv */
`timescale 1ns / 1ps

module tb_json_string_unescape_utf8;
    import jsu_pkg::*;

    localparam int CYCLE_LIMIT  = 400_000;
    localparam int RAND_ITEMS   = 430;
    localparam int HOLD_CYCLES  = 120;
    localparam int HOLD_AFTER   = 80;

    typedef struct {
        logic [7:0] data;
        logic       eoi;
    } t_raw_item;

    typedef struct {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last;
        logic       string_done;
        t_err       error_code;
    } t_decoded;

    class unescape_checker;
        t_mode       mode;
        logic [1:0]  hex_cnt;
        logic [15:0] code_unit;
        logic [9:0]  high_sur;
        t_decoded    utf8_expected[$];
        int          errors;
        int          checked;

        function new();
            clear_state();
            errors  = 0;
            checked = 0;
        endfunction

        static function int hex_digit(logic [7:0] c);
            if (c >= "0" && c <= "9") return int'(c) - int'("0");
            if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
            if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
            return -1;
        endfunction

        function void clear_state();
            mode      = M_IDLE;
            hex_cnt   = '0;
            code_unit = '0;
            high_sur  = '0;
        endfunction

        function void push(logic [7:0] b, logic bv, logic lst, logic dn, t_err e);
            t_decoded r;
            r.out_byte    = b;
            r.byte_valid  = bv;
            r.last        = lst;
            r.string_done = dn;
            r.error_code  = e;
            utf8_expected = {utf8_expected, r};
        endfunction

        function void abort(t_err e);
            clear_state();
            push(8'h00, 1'b0, 1'b1, 1'b0, e);
        endfunction

        function void emit_cp(logic [20:0] cp);
            if (cp <= 21'h7F) begin
                push(cp[7:0], 1'b1, 1'b1, 1'b0, ERR_NONE);
            end else if (cp <= 21'h7FF) begin
                push({3'b110, cp[10:6]}, 1'b1, 1'b0, 1'b0, ERR_NONE);
                push({2'b10, cp[5:0]}, 1'b1, 1'b1, 1'b0, ERR_NONE);
            end else if (cp <= 21'hFFFF) begin
                push({4'b1110, cp[15:12]}, 1'b1, 1'b0, 1'b0, ERR_NONE);
                push({2'b10, cp[11:6]}, 1'b1, 1'b0, 1'b0, ERR_NONE);
                push({2'b10, cp[5:0]}, 1'b1, 1'b1, 1'b0, ERR_NONE);
            end else begin
                push({5'b11110, cp[20:18]}, 1'b1, 1'b0, 1'b0, ERR_NONE);
                push({2'b10, cp[17:12]}, 1'b1, 1'b0, 1'b0, ERR_NONE);
                push({2'b10, cp[11:6]}, 1'b1, 1'b0, 1'b0, ERR_NONE);
                push({2'b10, cp[5:0]}, 1'b1, 1'b1, 1'b0, ERR_NONE);
            end
            mode = M_BODY;
        endfunction

        function void simple_esc(logic [7:0] b);
            mode = M_BODY;
            push(b, 1'b1, 1'b1, 1'b0, ERR_NONE);
        endfunction

        function void take_raw_byte(logic [7:0] c, logic eoi);
            int d;
            logic [20:0] cp;
            if (eoi) begin
                case (mode)
                    M_IDLE:   abort(ERR_NO_QUOTE);
                    M_EXP_BS: abort(ERR_EXP_BS);
                    M_EXP_U:  abort(ERR_EXP_U);
                    default:  abort(ERR_UNTERM);
                endcase
                return;
            end
            case (mode)
                M_IDLE: begin
                    if (c != CH_QUOTE) abort(ERR_NO_QUOTE);
                    else mode = M_BODY;
                end
                M_BODY: begin
                    if (c == CH_QUOTE) begin
                        mode = M_IDLE;
                        push(8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE);
                    end else if (c < CTRL_LIMIT) begin
                        abort(ERR_CTRL);
                    end else if (c == CH_BSLASH) begin
                        mode = M_ESC;
                    end else begin
                        push(c, 1'b1, 1'b1, 1'b0, ERR_NONE);
                    end
                end
                M_ESC: begin
                    case (c)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: simple_esc(c);
                        CH_B: simple_esc(CC_BS);
                        CH_F: simple_esc(CC_FF);
                        CH_N: simple_esc(CC_LF);
                        CH_R: simple_esc(CC_CR);
                        CH_T: simple_esc(CC_TAB);
                        CH_U: begin
                            mode      = M_HEX1;
                            hex_cnt   = '0;
                            code_unit = '0;
                        end
                        default: abort(ERR_BAD_ESC);
                    endcase
                end
                M_EXP_BS: begin
                    if (c != CH_BSLASH) abort(ERR_EXP_BS);
                    else mode = M_EXP_U;
                end
                M_EXP_U: begin
                    if (c != CH_U) begin
                        abort(ERR_EXP_U);
                    end else begin
                        mode      = M_HEX2;
                        hex_cnt   = '0;
                        code_unit = '0;
                    end
                end
                default: begin
                    d = hex_digit(c);
                    if (d < 0) begin
                        abort(ERR_BAD_HEX);
                        return;
                    end
                    code_unit = {code_unit[11:0], 4'(d)};
                    if (hex_cnt != 2'd3) begin
                        hex_cnt = hex_cnt + 2'd1;
                        return;
                    end
                    hex_cnt = '0;
                    if (mode == M_HEX1) begin
                        if (code_unit >= 16'hD800 && code_unit <= 16'hDBFF) begin
                            high_sur = code_unit[9:0];
                            mode     = M_EXP_BS;
                        end else if (code_unit >= 16'hDC00 && code_unit <= 16'hDFFF) begin
                            abort(ERR_LONE_LOW);
                        end else begin
                            emit_cp({5'd0, code_unit});
                        end
                    end else begin
                        if (code_unit < 16'hDC00 || code_unit > 16'hDFFF) begin
                            abort(ERR_BAD_PAIR);
                        end else begin
                            cp = 21'h10000 + {1'b0, high_sur, 10'd0}
                                 + {11'd0, code_unit[9:0]};
                            emit_cp(cp);
                        end
                    end
                end
            endcase
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task match_decoded(logic [7:0] ob, logic bv, logic lst, logic dn, logic [3:0] ec);
            t_decoded e;
            checked++;
            if (utf8_expected.size() == 0) begin
                report($sformatf("unexpected result byte=%02h bv=%0b last=%0b done=%0b err=%0d",
                                 ob, bv, lst, dn, ec));
                return;
            end
            e = utf8_expected.pop_front();
            if (ob !== e.out_byte)
                report($sformatf("out_byte %02h, want %02h", ob, e.out_byte));
            if (bv !== e.byte_valid)
                report($sformatf("byte_valid %0b, want %0b", bv, e.byte_valid));
            if (lst !== e.last)
                report($sformatf("last %0b, want %0b", lst, e.last));
            if (dn !== e.string_done)
                report($sformatf("string_done %0b, want %0b", dn, e.string_done));
            if (ec !== e.error_code)
                report($sformatf("error_code %0d, want %0d", ec, e.error_code));
        endtask

        function int pending();
            return utf8_expected.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   rst_done;
    bit   flood;
    int   cycles;

    t_raw_item       raw_q[$];
    unescape_checker sb;

    jsu_in_if  in_if ();
    jsu_out_if out_if ();

    json_string_unescape_utf8 u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("json_string_unescape_utf8 verification failed");
            $finish;
        end
    end

    function automatic void add_byte(logic [7:0] b);
        t_raw_item it;
        it.data = b;
        it.eoi  = 1'b0;
        raw_q   = {raw_q, it};
    endfunction

    function automatic void add_eoi();
        t_raw_item it;
        it.data = 8'($urandom_range(0, 255));
        it.eoi  = 1'b1;
        raw_q   = {raw_q, it};
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endfunction

    function automatic void add_hex4(logic [15:0] v);
        logic [3:0] n;
        for (int i = 3; i >= 0; i--) begin
            n = v[i*4 +: 4];
            if (n < 4'd10) add_byte(8'("0") + 8'(n));
            else if ($urandom_range(0, 1)) add_byte(8'("a") + 8'(n) - 8'd10);
            else add_byte(8'("A") + 8'(n) - 8'd10);
        end
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(8'h20, 8'hFF));
        while (b == CH_QUOTE || b == CH_BSLASH);
        return b;
    endfunction

    function automatic logic [15:0] high_unit();
        return 16'($urandom_range(16'hD800, 16'hDBFF));
    endfunction

    function automatic void add_element();
        logic [7:0]  esc_set [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};
        logic [15:0] v;
        int          k;
        k = $urandom_range(0, 9);
        if (k <= 3) begin
            add_byte(plain_byte());
        end else if (k <= 5) begin
            add_byte(CH_BSLASH);
            add_byte(esc_set[$urandom_range(0, 7)]);
        end else if (k <= 7) begin
            case ($urandom_range(0, 2))
                0: v = 16'($urandom_range(0, 16'h7F));
                1: v = 16'($urandom_range(16'h80, 16'h7FF));
                default: begin
                    do v = 16'($urandom_range(16'h800, 16'hFFFF));
                    while (v >= 16'hD800 && v <= 16'hDFFF);
                end
            endcase
            add_text("\\u");
            add_hex4(v);
        end else begin
            add_text("\\u");
            add_hex4(high_unit());
            add_text("\\u");
            add_hex4(16'($urandom_range(16'hDC00, 16'hDFFF)));
        end
    endfunction

    function automatic void add_broken_tail();
        logic [7:0]  b;
        logic [15:0] v;
        case ($urandom_range(0, 8))
            0: add_eoi();
            1: add_byte(8'($urandom_range(0, 8'h1F)));
            2: begin
                add_byte(CH_BSLASH);
                do b = 8'($urandom_range(0, 255));
                while (b inside {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N,
                                 CH_R, CH_T, CH_U});
                add_byte(b);
            end
            3: begin
                add_text("\\u");
                repeat ($urandom_range(0, 3)) add_byte(8'("0") + 8'($urandom_range(0, 9)));
                if ($urandom_range(0, 3) == 0) begin
                    add_eoi();
                end else begin
                    do b = 8'($urandom_range(0, 255));
                    while (unescape_checker::hex_digit(b) >= 0);
                    add_byte(b);
                end
            end
            4: begin
                add_text("\\u");
                add_hex4(16'($urandom_range(16'hDC00, 16'hDFFF)));
            end
            5: begin
                add_text("\\u");
                add_hex4(high_unit());
                add_text("\\u");
                do v = 16'($urandom_range(0, 16'hFFFF));
                while (v >= 16'hDC00 && v <= 16'hDFFF);
                add_hex4(v);
            end
            6: begin
                add_text("\\u");
                add_hex4(high_unit());
                if ($urandom_range(0, 2) == 0) begin
                    add_eoi();
                end else begin
                    do b = 8'($urandom_range(0, 255));
                    while (b == CH_BSLASH);
                    add_byte(b);
                end
            end
            7: begin
                add_text("\\u");
                add_hex4(high_unit());
                add_byte(CH_BSLASH);
                if ($urandom_range(0, 2) == 0) begin
                    add_eoi();
                end else begin
                    do b = 8'($urandom_range(0, 255));
                    while (b == CH_U);
                    add_byte(b);
                end
            end
            default: begin
                add_byte(CH_BSLASH);
                add_eoi();
            end
        endcase
    endfunction

    function automatic void add_string();
        if ($urandom_range(0, 99) < 8) begin
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(0, 2) == 0) add_eoi();
                else add_byte(8'($urandom_range(0, 255)));
            end
            return;
        end
        add_byte(CH_QUOTE);
        repeat ($urandom_range(0, 6)) add_element();
        if ($urandom_range(0, 99) < 70) add_byte(CH_QUOTE);
        else add_broken_tail();
    endfunction

    function automatic int draw_gap(int idx);
        if (flood || (idx % 64) < 16) return 0;
        if ($urandom_range(0, 2) == 0) return $urandom_range(0, 18);
        return $urandom_range(0, 3);
    endfunction

    // one transfer; entered and left at a falling edge
    task automatic drive_item(t_raw_item it, int gap);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.data_byte    <= it.data;
        in_if.end_of_input <= it.eoi;
        do @(posedge i_clk);
        while (in_if.ready !== 1'b1);
        sb.take_raw_byte(it.data, it.eoi);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        do @(negedge i_clk);
        while (sb.pending() != 0);
    endtask

    task automatic send_raw(bit pause_mid);
        int half;
        half = raw_q.size() / 2;
        for (int i = 0; i < raw_q.size(); i++) begin
            if (pause_mid && i == half) wait_drained();
            drive_item(raw_q[i], draw_gap(i));
        end
        raw_q.delete();
    endtask

    initial begin
        int gap;
        bit held;
        out_if.ready = 1'b0;
        held = 1'b0;
        while (!rst_done) @(negedge i_clk);
        forever begin
            if (!held && sb.checked >= HOLD_AFTER) begin
                held = 1'b1;
                flood = 1'b1;
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                flood = 1'b0;
            end
            if ((sb.checked % 48) < 12) gap = 0;
            else if ($urandom_range(0, 2) == 0) gap = $urandom_range(0, 18);
            else gap = $urandom_range(0, 2);
            if (gap > 0) begin
                out_if.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk);
            while (out_if.valid !== 1'b1);
            sb.match_decoded(out_if.out_byte, out_if.byte_valid, out_if.last,
                             out_if.string_done, out_if.error_code);
            @(negedge i_clk);
        end
    end

    initial begin
        sb                 = new();
        cycles             = 0;
        rst_done           = 1'b0;
        flood              = 1'b0;
        i_rst_n            = 1'b0;
        in_if.valid        = 1'b0;
        in_if.data_byte    = 8'h00;
        in_if.end_of_input = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n  <= 1'b1;
        rst_done = 1'b1;
        @(negedge i_clk);

        // end while idle, control byte, byte extremes, control byte in an escape,
        // smallest code point and largest surrogate pair
        add_eoi();
        add_byte(CH_QUOTE);
        add_byte(8'h00);
        add_byte(CH_QUOTE);
        add_byte(8'hFF);
        add_byte(8'h20);
        add_byte(CH_BSLASH);
        add_byte(8'h1F);
        add_text("\"\\u0000\\udBfF\\uDfFf\"");
        send_raw(1'b0);
        wait_drained();

        while (raw_q.size() < RAND_ITEMS) add_string();
        send_raw(1'b1);
        wait_drained();
        repeat (16) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("json_string_unescape_utf8 verification clean");
        end else begin
            $display("json_string_unescape_utf8 verification failed");
        end
        $finish;
    end

endmodule
